### hw/rtl/sild_pkg.sv
// Shared constants, types and helpers for the serial image loader deframer.
// Holds the sync word, the reset load base and the packed result item.
// No dependencies.
package sild_pkg;

  localparam int unsigned ADDR_WIDTH = 32;
  localparam logic [63:0] ADDR_MASK =
      (ADDR_WIDTH >= 64) ? '1 : ((64'd1 << ADDR_WIDTH) - 64'd1);

  localparam logic [31:0] LOAD_BASE_RESET = 32'h0008_0000;
  localparam logic [2:0]  SYNC_LEN        = 3'd5;

  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_R = 8'h52;

  // Output tdata width; the result item below lists its fields top bit first
  localparam int unsigned TDATA_BITS = 80;

  typedef struct packed {
    logic [30:0] announced_size;
    logic        load_done;
    logic [1:0]  phase_after;
    logic [7:0]  write_data;
    logic [31:0] write_address;
    logic        write_enable;
  } res_t;

  // Letter of the sync word "START" at a given match position
  function automatic logic [7:0] sync_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CH_S;
      3'd1:    c = CH_T;
      3'd2:    c = CH_A;
      3'd3:    c = CH_R;
      3'd4:    c = CH_T;
      default: c = CH_S;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/serial_image_loader_deframer.sv
// Top level of the serial image loader deframer: sync hunt, size header and
// payload address generation, with a one-item skid stage on the result side.
// Depends on sild_pkg.
//
// Usage:
//   s_axis carries received serial bytes (tdata[7:0] = rx_byte). For every
//   accepted byte exactly one result item leaves on m_axis:
//     tuser       write_enable
//     tlast       load_done
//     tdata[31:0] write_address, [39:32] write_data, [41:40] phase_after,
//     [72:42] announced_size, upper bits zero.
//   The block hunts for "START", reads a 4-byte little-endian size and then
//   emits that many payload writes at load_base plus offset.
//   load_base is written through cfg_wr_en/cfg_wr_data while idle; the
//   user is bound to this, the block itself does not enforce it.
// One byte is taken every cycle unless the skid register is full. When
// the receiver stalls, one further item is caught in the skid register
// and s_axis_tready drops until it drains.
// Reset returns to hunting, clears the counters, restores load_base to
// 0x80000 and empties the output stages.
module serial_image_loader_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [sild_pkg::TDATA_BITS-1:0] m_axis_tdata,
  // [31:0] write_address, [39:32] write_data, [41:40] phase_after,
  // [72:42] announced_size, [79:73] zero
  output logic        m_axis_tuser,   // [0] write_enable
  output logic        m_axis_tlast    // load_done
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SIZE = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  phase_t       phase, phase_next;
  logic [2:0]   sync_matched, sync_matched_next;
  logic [1:0]   size_idx, size_idx_next;
  logic [31:0]  image_size, image_size_next;
  logic [30:0]  bytes_rcv, bytes_rcv_next;
  logic [31:0]  load_base;

  sild_pkg::res_t res, out_res, skid_res;
  logic           skid_valid;

  logic        accept, out_take;
  logic [7:0]  b;
  logic [2:0]  m;
  logic [30:0] eff_size;
  logic [31:0] cnt_inc;
  logic [31:0] addr_sum;

  assign b        = s_axis_tdata;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !skid_valid;

  assign m       = (sync_matched < sild_pkg::SYNC_LEN) ? sync_matched : 3'd0;
  assign cnt_inc = {1'b0, bytes_rcv} + 32'd1;
  assign addr_sum = (load_base + {1'b0, bytes_rcv}) & sild_pkg::ADDR_MASK[31:0];

  always_comb begin
    phase_next        = phase;
    sync_matched_next = sync_matched;
    size_idx_next     = size_idx;
    image_size_next   = image_size;
    bytes_rcv_next    = bytes_rcv;
    eff_size          = image_size[31] ? 31'd0 : image_size[30:0];
    res               = '0;
    case (phase)
      PH_SIZE: begin
        image_size_next = image_size | (32'(b) << {size_idx, 3'b000});
        if (size_idx == 2'd3) begin
          eff_size = image_size_next[31] ? 31'd0 : image_size_next[30:0];
          res.announced_size = eff_size;
          size_idx_next  = 2'd0;
          bytes_rcv_next = '0;
          if (eff_size == 31'd0) begin
            res.load_done     = 1'b1;
            phase_next        = PH_HUNT;
            sync_matched_next = 3'd0;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          size_idx_next = size_idx + 2'd1;
        end
      end
      PH_DATA: begin
        res.write_enable   = 1'b1;
        res.write_address  = addr_sum;
        res.write_data     = b;
        res.announced_size = eff_size;
        bytes_rcv_next     = cnt_inc[30:0];
        if (cnt_inc >= {1'b0, eff_size}) begin
          res.load_done     = 1'b1;
          phase_next        = PH_HUNT;
          sync_matched_next = 3'd0;
          bytes_rcv_next    = '0;
        end
      end
      default: begin
        // unused phase code falls back to hunting
        phase_next = PH_HUNT;
        if (b == sild_pkg::sync_char(m)) begin
          if (m == sild_pkg::SYNC_LEN - 3'd1) begin
            sync_matched_next = 3'd0;
            phase_next        = PH_SIZE;
            size_idx_next     = 2'd0;
            image_size_next   = '0;
          end else begin
            sync_matched_next = m + 3'd1;
          end
        end else begin
          // restart, but a mismatching S opens a new match
          sync_matched_next = (b == sild_pkg::sync_char(3'd0)) ? 3'd1 : 3'd0;
        end
      end
    endcase
    res.phase_after = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      sync_matched  <= 3'd0;
      size_idx      <= 2'd0;
      image_size    <= '0;
      bytes_rcv     <= '0;
      load_base     <= sild_pkg::LOAD_BASE_RESET;
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        load_base <= cfg_wr_data;
      end
      if (accept) begin
        phase        <= phase_next;
        sync_matched <= sync_matched_next;
        size_idx     <= size_idx_next;
        image_size   <= image_size_next;
        bytes_rcv    <= bytes_rcv_next;
        if (!m_axis_tvalid || out_take) begin
          out_res       <= res;
          m_axis_tvalid <= 1'b1;
        end else begin
          // receiver stalled: park the item in the skid stage
          skid_res   <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end else begin
          m_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  assign m_axis_tdata = {7'd0, out_res.announced_size, out_res.phase_after,
                         out_res.write_data, out_res.write_address};
  assign m_axis_tuser = out_res.write_enable;
  assign m_axis_tlast = out_res.load_done;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid stage holds an item while the output stage is empty");

  a_done_hunts: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[41:40] == PH_HUNT))
    else $error("load done without return to sync hunt");

  a_idle_write_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[39:0] == 40'd0))
    else $error("address or data set on an item that is not a write");

  a_data_size_valid: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (!image_size[31] && image_size != 32'd0))
    else $error("payload phase entered with an empty image size");

  a_size_idx_hunt: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_SIZE && size_idx == 2'd3) |=> (size_idx == 2'd0))
    else $error("size byte index not cleared after the last size byte");

endmodule

### test/sild_result_checker.sv
// Result checker for the serial image loader deframer: mirrors the sync hunt,
// size header and payload addressing, and compares every result item it sees.
// Depends on sild_pkg.
module sild_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [31:0]                     cfg_wr_data,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [sild_pkg::TDATA_BITS-1:0] m_axis_tdata,
  input  logic                            m_axis_tuser,
  input  logic                            m_axis_tlast,
  output int                              mismatch_count,
  output int                              results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    LD_HUNT    = 2'd0,
    LD_SIZE    = 2'd1,
    LD_PAYLOAD = 2'd2
  } loader_phase_e;

  localparam logic [39:0] SYNC_TEXT = "START";

  logic [31:0]   base_addr;
  loader_phase_e ld_phase;
  logic [2:0]    letters_seen;
  logic [1:0]    size_pos;
  logic [31:0]   size_word;
  logic [31:0]   payload_count;

  sild_pkg::res_t expected_results[$];

  function automatic logic [31:0] image_length(input logic [31:0] raw);
    return raw[31] ? 32'd0 : raw;
  endfunction

  // Advance the loader by one received byte and form the result item it gives
  task automatic advance_loader(input logic [7:0] rx, output sild_pkg::res_t r);
    logic [31:0] len;
    logic [2:0]  m;
    logic [63:0] addr;
    r = '0;
    case (ld_phase)
      LD_SIZE: begin
        size_word = size_word | (32'(rx) << (int'(size_pos) * 8));
        if (size_pos == 2'd3) begin
          len = image_length(size_word);
          r.announced_size = len[30:0];
          size_pos = 2'd0;
          payload_count = 32'd0;
          if (len == 32'd0) begin
            r.load_done = 1'b1;
            ld_phase = LD_HUNT;
            letters_seen = 3'd0;
          end else begin
            ld_phase = LD_PAYLOAD;
          end
        end else begin
          size_pos = size_pos + 2'd1;
        end
      end
      LD_PAYLOAD: begin
        len = image_length(size_word);
        addr = (64'(base_addr) + 64'(payload_count)) & sild_pkg::ADDR_MASK;
        r.write_enable = 1'b1;
        r.write_address = addr[31:0];
        r.write_data = rx;
        r.announced_size = len[30:0];
        payload_count = payload_count + 32'd1;
        if (payload_count >= len) begin
          r.load_done = 1'b1;
          ld_phase = LD_HUNT;
          letters_seen = 3'd0;
          payload_count = 32'd0;
        end
      end
      default: begin
        m = (letters_seen < sild_pkg::SYNC_LEN) ? letters_seen : 3'd0;
        ld_phase = LD_HUNT;
        if (rx == SYNC_TEXT[39 - 8 * int'(m) -: 8]) begin
          m = m + 3'd1;
          if (m == sild_pkg::SYNC_LEN) begin
            m = 3'd0;
            ld_phase = LD_SIZE;
            size_pos = 2'd0;
            size_word = 32'd0;
          end
        end else begin
          // a stray S still starts a new match
          m = (rx == SYNC_TEXT[39 -: 8]) ? 3'd1 : 3'd0;
        end
        letters_seen = m;
      end
    endcase
    r.phase_after = ld_phase;
  endtask

  always @(posedge clk) begin
    sild_pkg::res_t want;
    sild_pkg::res_t seen;
    sild_pkg::res_t next_r;
    logic [6:0] pad;
    logic bad;
    if (rst) begin
      base_addr = sild_pkg::LOAD_BASE_RESET;
      ld_phase = LD_HUNT;
      letters_seen = 3'd0;
      size_pos = 2'd0;
      size_word = 32'd0;
      payload_count = 32'd0;
      expected_results.delete();
      mismatch_count = 0;
      results_due <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.write_enable = m_axis_tuser;
        seen.load_done = m_axis_tlast;
        seen.write_address = m_axis_tdata[31:0];
        seen.write_data = m_axis_tdata[39:32];
        seen.phase_after = m_axis_tdata[41:40];
        seen.announced_size = m_axis_tdata[72:42];
        pad = m_axis_tdata[79:73];
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result item with none expected: addr=%h data=%h", $realtime,
                     seen.write_address, seen.write_data);
        end else begin
          want = expected_results.pop_front();
          bad = (seen.write_enable !== want.write_enable) ||
                (seen.write_address !== want.write_address) ||
                (seen.write_data !== want.write_data) ||
                (seen.phase_after !== want.phase_after) ||
                (seen.load_done !== want.load_done) ||
                (seen.announced_size !== want.announced_size) ||
                (pad !== 7'd0);
          if (bad) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch exp we=%0d addr=%h data=%h ph=%0d done=%0d size=%0d",
                       $realtime, want.write_enable, want.write_address, want.write_data,
                       want.phase_after, want.load_done, want.announced_size);
              $display("        got we=%0d addr=%h data=%h ph=%0d done=%0d size=%0d pad=%h",
                       seen.write_enable, seen.write_address, seen.write_data,
                       seen.phase_after, seen.load_done, seen.announced_size, pad);
            end
          end
        end
      end
      if (cfg_wr_en)
        base_addr = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        advance_loader(s_axis_tdata, next_r);
        expected_results.push_back(next_r);
      end
      results_due <= expected_results.size();
    end
  end

endmodule

### test/serial_image_loader_deframer_tb.sv
// Testbench top for the serial image loader deframer: drives framed and noisy
// byte streams with random gaps and back-pressure, and reports the verdict.
// Depends on sild_pkg, sild_result_checker and the deframer RTL.
module serial_image_loader_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          PHASE_ITEMS = 350;
  localparam logic [39:0] SYNC_TEXT   = "START";

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [sild_pkg::TDATA_BITS-1:0] m_axis_tdata;
  // [31:0] write_address, [39:32] write_data, [41:40] phase_after,
  // [72:42] announced_size, [79:73] zero
  logic        m_axis_tuser;   // [0] write_enable
  logic        m_axis_tlast;   // load_done

  int          mismatch_count;
  int          results_due;
  int          cycle_count = 0;
  logic        quiet_link;
  logic [7:0]  frame_bytes[$];

  serial_image_loader_deframer uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sild_result_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: runs of ready and stall, mostly short
  initial begin
    int hold;
    int pick;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet_link) begin
        m_axis_tready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          m_axis_tready <= 1'b1;
          hold = $urandom_range(1, 8);
        end else if (pick < 85) begin
          m_axis_tready <= 1'b0;
          hold = $urandom_range(1, 3);
        end else if (pick < 95) begin
          m_axis_tready <= 1'b0;
          hold = $urandom_range(4, 12);
        end else if (pick < 98) begin
          m_axis_tready <= 1'b0;
          hold = $urandom_range(20, 40);
        end else begin
          m_axis_tready <= 1'b1;
          hold = $urandom_range(50, 200);
        end
      end
    end
  end

  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet_link || pick < 55)
      return 0;
    if (pick < 85)
      return $urandom_range(1, 3);
    if (pick < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [7:0] sync_letter(input int pos);
    return SYNC_TEXT[39 - 8 * pos -: 8];
  endfunction

  // Noise never holds a T, so it can never finish a sync word on its own
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do
      b = 8'($urandom_range(0, 255));
    while (b == sild_pkg::CH_T);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int  gap;
    bit  took;
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send_header(input logic [31:0] len);
    for (int i = 0; i < 5; i++)
      send_byte(sync_letter(i));
    for (int i = 0; i < 4; i++)
      send_byte(len[8 * i +: 8]);
  endtask

  // Drain every result, then write the load base while the block is idle
  task automatic set_load_base(input logic [31:0] base);
    s_axis_tvalid <= 1'b0;
    do
      @(negedge clk);
    while (results_due != 0);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic build_frame();
    int          pick;
    int          k;
    logic [31:0] len;
    logic [7:0]  b;
    frame_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) frame_bytes.push_back(noise_byte());
      for (int i = 0; i < 5; i++)
        frame_bytes.push_back(sync_letter(i));
      k = $urandom_range(0, 99);
      if (k < 80)
        len = $urandom_range(1, 12);
      else if (k < 88)
        len = $urandom_range(13, 48);
      else if (k < 94)
        len = 32'd0;
      else
        len = {1'b1, 31'($urandom())};
      for (int i = 0; i < 4; i++)
        frame_bytes.push_back(len[8 * i +: 8]);
      if (!len[31]) begin
        for (int i = 0; i < int'(len); i++) begin
          if ($urandom_range(0, 4) == 0)
            frame_bytes.push_back(sync_letter($urandom_range(0, 4)));
          else
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
    end else if (pick < 88) begin
      // Broken sync: a prefix of the word, then a wrong letter
      k = $urandom_range(1, 4);
      for (int i = 0; i < k; i++)
        frame_bytes.push_back(sync_letter(i));
      do
        b = noise_byte();
      while (b == sync_letter(k));
      frame_bytes.push_back(b);
      repeat ($urandom_range(0, 2)) frame_bytes.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(noise_byte());
    end
  endtask

  initial begin
    int sent;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 32'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    quiet_link = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Doubled S before the sync word, then a zero size
    send_byte(sild_pkg::CH_S);
    send_header(32'd0);
    // Size with the top bit set gives an empty image
    send_header(32'h8000_0000);
    // Two payload bytes from the top of the address space, the second wraps to zero
    set_load_base(32'hFFFF_FFFF);
    send_header(32'd2);
    send_byte(8'hFF);
    send_byte(8'h00);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       set_load_base(sild_pkg::LOAD_BASE_RESET);
        1:       set_load_base(32'h0000_0000);
        2:       set_load_base(32'hFFFF_FFF8);
        3:       set_load_base($urandom());
        default: set_load_base(32'h7FFF_FFF0);
      endcase
      quiet_link <= (ph == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_frame();
        foreach (frame_bytes[i])
          send_byte(frame_bytes[i]);
        sent += frame_bytes.size();
      end
    end

    s_axis_tvalid <= 1'b0;
    do
      @(negedge clk);
    while (results_due != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
